### rtl/core/dominoex_ifk_tone_encoder_unit_defines.svh
// Assertion macros shared by the tone encoder modules
`ifndef DOMINOEX_IFK_TONE_ENCODER_UNIT_DEFINES_SVH
`define DOMINOEX_IFK_TONE_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DXIFK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define DXIFK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dxifk_pkg.sv
// Types, constants and varicode table for the IFK+ tone encoder
package dxifk_pkg;

  localparam int unsigned TONE_COUNT = 18;
  localparam int unsigned IFK_OFFSET = 2;
  localparam int unsigned TONE_W     = 5;
  localparam int unsigned DAC_W      = 12;
  localparam int unsigned SPACING_W  = 8;
  localparam int unsigned ENTRY_W    = 12;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned CONT_BIT   = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TONE_SPACING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL   = 1'd1;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd25;
  localparam logic [DAC_W-1:0]     BASE_RESET    = 12'd2103;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dxifk_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic last;
  } dxifk_sts_t;

  // Primary varicode: first nibble in [11:8], continuations in [7:4] and [3:0]
  localparam logic [ENTRY_W-1:0] VARICODE_ROM [0:255] = '{
    12'h1F9,12'h1FA,12'h1FB,12'h1FC,12'h1FD,12'h1FE,12'h1FF,12'h288,
    12'h2C0,12'h289,12'h28A,12'h28B,12'h28C,12'h2D0,12'h28D,12'h28E,
    12'h28F,12'h298,12'h299,12'h29A,12'h29B,12'h29C,12'h29D,12'h29E,
    12'h29F,12'h2A8,12'h2A9,12'h2AA,12'h2AB,12'h2AC,12'h2AD,12'h2AE,
    12'h000,12'h7B0,12'h08E,12'h0AB,12'h09A,12'h099,12'h08F,12'h7A0,
    12'h08C,12'h08B,12'h09D,12'h088,12'h2B0,12'h7E0,12'h7D0,12'h089,
    12'h3F0,12'h4A0,12'h4F0,12'h590,12'h680,12'h5C0,12'h5E0,12'h6C0,
    12'h6B0,12'h6E0,12'h08A,12'h08D,12'h0A8,12'h7F0,12'h09F,12'h7C0,
    12'h098,12'h390,12'h4E0,12'h3C0,12'h3E0,12'h380,12'h4C0,12'h580,
    12'h5A0,12'h3A0,12'h780,12'h6A0,12'h4B0,12'h480,12'h4D0,12'h3B0,
    12'h490,12'h6F0,12'h3D0,12'h2F0,12'h2E0,12'h5B0,12'h6D0,12'h5D0,
    12'h5F0,12'h690,12'h790,12'h0AE,12'h0A9,12'h0AF,12'h0AA,12'h09C,
    12'h09B,12'h400,12'h1B0,12'h0C0,12'h0B0,12'h100,12'h0F0,12'h190,
    12'h0A0,12'h500,12'h2A0,12'h1E0,12'h090,12'h0E0,12'h600,12'h300,
    12'h180,12'h280,12'h700,12'h080,12'h200,12'h0D0,12'h1D0,12'h1C0,
    12'h1F0,12'h1A0,12'h290,12'h0AC,12'h09E,12'h0AD,12'h0B8,12'h2AF,
    12'h2B8,12'h2B9,12'h2BA,12'h2BB,12'h2BC,12'h2BD,12'h2BE,12'h2BF,
    12'h2C8,12'h2C9,12'h2CA,12'h2CB,12'h2CC,12'h2CD,12'h2CE,12'h2CF,
    12'h2D8,12'h2D9,12'h2DA,12'h2DB,12'h2DC,12'h2DD,12'h2DE,12'h2DF,
    12'h2E8,12'h2E9,12'h2EA,12'h2EB,12'h2EC,12'h2ED,12'h2EE,12'h2EF,
    12'h0B9,12'h0BA,12'h0BB,12'h0BC,12'h0BD,12'h0BE,12'h0BF,12'h0C8,
    12'h0C9,12'h0CA,12'h0CB,12'h0CC,12'h0CD,12'h0CE,12'h0CF,12'h0D8,
    12'h0D9,12'h0DA,12'h0DB,12'h0DC,12'h0DD,12'h0DE,12'h0DF,12'h0E8,
    12'h0E9,12'h0EA,12'h0EB,12'h0EC,12'h0ED,12'h0EE,12'h0EF,12'h0F8,
    12'h0F9,12'h0FA,12'h0FB,12'h0FC,12'h0FD,12'h0FE,12'h0FF,12'h188,
    12'h189,12'h18A,12'h18B,12'h18C,12'h18D,12'h18E,12'h18F,12'h198,
    12'h199,12'h19A,12'h19B,12'h19C,12'h19D,12'h19E,12'h19F,12'h1A8,
    12'h1A9,12'h1AA,12'h1AB,12'h1AC,12'h1AD,12'h1AE,12'h1AF,12'h1B8,
    12'h1B9,12'h1BA,12'h1BB,12'h1BC,12'h1BD,12'h1BE,12'h1BF,12'h1C8,
    12'h1C9,12'h1CA,12'h1CB,12'h1CC,12'h1CD,12'h1CE,12'h1CF,12'h1D8,
    12'h1D9,12'h1DA,12'h1DB,12'h1DC,12'h1DD,12'h1DE,12'h1DF,12'h1E8,
    12'h1E9,12'h1EA,12'h1EB,12'h1EC,12'h1ED,12'h1EE,12'h1EF,12'h1F8
  };

endpackage

### rtl/core/dominoex_ifk_tone_encoder_unit.sv
// IFK+ tone encoder: top level joining controller and datapath
//
// Input channel: char_code with in_valid/in_ready. A character is looked up
// in the primary varicode table and gives one to three tones.
// Output channel: tone_index, dac_code, last_symbol with out_valid/out_ready,
// one item per tone; last_symbol marks the final tone of a character.
// Each tone is (previous tone + 2 + nibble) mod 18, and dac_code is
// base_level + tone * tone_spacing, saturated at 4095.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 tone_spacing, 1 base_level); write only while the block is idle.
// A character is loaded when it is accepted; its tones then enter the
// output register in order, each one as soon as that register is free.
// The tone step feeds the next tone, so the tones of a character are
// produced one at a time. Reset clears the previous tone to zero and
// restores tone_spacing 25 and base_level 2103. When the receiver stalls,
// the held tone stays on the output and the next tone waits; in_ready
// stays low until the character's last tone is in the output register.
module dominoex_ifk_tone_encoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dxifk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dxifk_pkg::DAC_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dxifk_pkg::TONE_W-1:0]      tone_index,
  output logic [dxifk_pkg::DAC_W-1:0]       dac_code,
  output logic                              last_symbol
);

  dxifk_pkg::dxifk_cmd_t cmd;
  dxifk_pkg::dxifk_sts_t sts;

  dxifk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dxifk_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tone_index  (tone_index),
    .dac_code    (dac_code),
    .last_symbol (last_symbol)
  );

endmodule

### rtl/core/dxifk_ctrl.sv
// Controller state machine: takes a character, then steps out its tones
`include "dominoex_ifk_tone_encoder_unit_defines.svh"

module dxifk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dxifk_pkg::dxifk_sts_t sts,
  output dxifk_pkg::dxifk_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;

  // Take an item only between characters
  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_valid && (state == S_IDLE);
  assign cmd.emit = (state == S_EMIT) && sts.out_free;

  // Advance from load to emit, return to idle after the last tone
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cmd.emit && sts.last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DXIFK_ASSERT_NEXT(a_load_blocks, cmd.load, !in_ready, "ready stayed high after a load")
  `DXIFK_ASSERT_NEXT(a_last_idles, cmd.emit && sts.last, in_ready,
                     "controller did not return to idle after the last tone")

endmodule

### rtl/core/dxifk_datapath.sv
// Datapath: varicode lookup, IFK+ tone step, DAC code and output register
`include "dominoex_ifk_tone_encoder_unit_defines.svh"

module dxifk_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dxifk_pkg::dxifk_cmd_t                  cmd,
  output dxifk_pkg::dxifk_sts_t                  sts,
  input  logic                                   cfg_we,
  input  logic [dxifk_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dxifk_pkg::DAC_W-1:0]            cfg_data,
  input  logic [7:0]                             char_code,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dxifk_pkg::TONE_W-1:0]           tone_index,
  output logic [dxifk_pkg::DAC_W-1:0]            dac_code,
  output logic                                   last_symbol
);

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;
  localparam int unsigned SUM_W  = dxifk_pkg::TONE_W + 1;
  localparam int unsigned PROD_W = dxifk_pkg::TONE_W + dxifk_pkg::SPACING_W;
  localparam int unsigned DSUM_W = PROD_W + 1;

  logic [dxifk_pkg::ENTRY_W-1:0]   entry;
  logic [1:0]                      slot;
  logic [dxifk_pkg::TONE_W-1:0]    prev_tone;
  logic [dxifk_pkg::SPACING_W-1:0] tone_spacing;
  logic [dxifk_pkg::DAC_W-1:0]     base_level;

  logic [dxifk_pkg::NIBBLE_W-1:0]  nibble;
  logic                            last;
  logic [SUM_W-1:0]                tone_sum;
  logic [dxifk_pkg::TONE_W-1:0]    tone_next;
  logic [PROD_W-1:0]               prod;
  logic [DSUM_W-1:0]               dac_sum;
  logic [dxifk_pkg::DAC_W-1:0]     dac_next;

  // Pick the nibble for this slot; a clear continuation bit in the next nibble, or the third slot, ends the character
  always_comb begin
    unique case (slot)
      SLOT_FIRST: begin
        nibble = entry[11:8];
        last   = !entry[4 + dxifk_pkg::CONT_BIT];
      end
      SLOT_SECOND: begin
        nibble = entry[7:4];
        last   = !entry[dxifk_pkg::CONT_BIT];
      end
      SLOT_THIRD: begin
        nibble = entry[3:0];
        last   = 1'b1;
      end
      default: begin
        nibble = entry[11:8];
        last   = 1'b1;
      end
    endcase
  end

  // Tone step: sum stays below twice the tone count, so one subtract wraps it
  always_comb begin
    tone_sum = SUM_W'(prev_tone) + SUM_W'(dxifk_pkg::IFK_OFFSET) + SUM_W'(nibble);
    if (tone_sum >= SUM_W'(dxifk_pkg::TONE_COUNT)) begin
      tone_next = dxifk_pkg::TONE_W'(tone_sum - SUM_W'(dxifk_pkg::TONE_COUNT));
    end else begin
      tone_next = dxifk_pkg::TONE_W'(tone_sum);
    end
  end

  // DAC code with saturation at full scale
  always_comb begin
    prod    = PROD_W'(tone_next) * PROD_W'(tone_spacing);
    dac_sum = DSUM_W'(base_level) + DSUM_W'(prod);
    if (dac_sum > DSUM_W'({dxifk_pkg::DAC_W{1'b1}})) begin
      dac_next = {dxifk_pkg::DAC_W{1'b1}};
    end else begin
      dac_next = dac_sum[dxifk_pkg::DAC_W-1:0];
    end
  end

  assign sts.out_free = !out_valid || out_ready;
  assign sts.last     = last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_spacing <= dxifk_pkg::SPACING_RESET;
      base_level   <= dxifk_pkg::BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dxifk_pkg::REG_TONE_SPACING: tone_spacing <= cfg_data[dxifk_pkg::SPACING_W-1:0];
        dxifk_pkg::REG_BASE_LEVEL:   base_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Previous tone and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tone <= '0;
      slot      <= SLOT_FIRST;
    end else if (cmd.load) begin
      slot <= SLOT_FIRST;
    end else if (cmd.emit) begin
      prev_tone <= tone_next;
      slot      <= slot + 2'd1;
    end
  end

  // Hold the table entry for the current character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry <= dxifk_pkg::VARICODE_ROM[char_code];
    end
  end

  // Output register: fill on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tone_index  <= tone_next;
      dac_code    <= dac_next;
      last_symbol <= last;
    end
  end

  `DXIFK_ASSERT_SAME(a_tone_range, out_valid,
                     tone_index < dxifk_pkg::TONE_W'(dxifk_pkg::TONE_COUNT),
                     "tone index out of range")
  `DXIFK_ASSERT_NEXT(a_emit_tone_tracks, cmd.emit, out_valid && (tone_index == prev_tone),
                     "emitted tone does not match held previous tone")

endmodule

### tb/tb_dominoex_ifk_tone_encoder_unit.sv
// Self-checking testbench for the IFK+ varicode tone encoder
module tb_dominoex_ifk_tone_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TONES        = 18;
  localparam int unsigned STEP         = 2;
  localparam int unsigned DAC_TOP      = 4095;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT  = 3000;

  // Primary varicode, first nibble in [11:8], continuations below
  localparam logic [11:0] VARICODE [256] = '{
    12'h1F9,12'h1FA,12'h1FB,12'h1FC,12'h1FD,12'h1FE,12'h1FF,12'h288,
    12'h2C0,12'h289,12'h28A,12'h28B,12'h28C,12'h2D0,12'h28D,12'h28E,
    12'h28F,12'h298,12'h299,12'h29A,12'h29B,12'h29C,12'h29D,12'h29E,
    12'h29F,12'h2A8,12'h2A9,12'h2AA,12'h2AB,12'h2AC,12'h2AD,12'h2AE,
    12'h000,12'h7B0,12'h08E,12'h0AB,12'h09A,12'h099,12'h08F,12'h7A0,
    12'h08C,12'h08B,12'h09D,12'h088,12'h2B0,12'h7E0,12'h7D0,12'h089,
    12'h3F0,12'h4A0,12'h4F0,12'h590,12'h680,12'h5C0,12'h5E0,12'h6C0,
    12'h6B0,12'h6E0,12'h08A,12'h08D,12'h0A8,12'h7F0,12'h09F,12'h7C0,
    12'h098,12'h390,12'h4E0,12'h3C0,12'h3E0,12'h380,12'h4C0,12'h580,
    12'h5A0,12'h3A0,12'h780,12'h6A0,12'h4B0,12'h480,12'h4D0,12'h3B0,
    12'h490,12'h6F0,12'h3D0,12'h2F0,12'h2E0,12'h5B0,12'h6D0,12'h5D0,
    12'h5F0,12'h690,12'h790,12'h0AE,12'h0A9,12'h0AF,12'h0AA,12'h09C,
    12'h09B,12'h400,12'h1B0,12'h0C0,12'h0B0,12'h100,12'h0F0,12'h190,
    12'h0A0,12'h500,12'h2A0,12'h1E0,12'h090,12'h0E0,12'h600,12'h300,
    12'h180,12'h280,12'h700,12'h080,12'h200,12'h0D0,12'h1D0,12'h1C0,
    12'h1F0,12'h1A0,12'h290,12'h0AC,12'h09E,12'h0AD,12'h0B8,12'h2AF,
    12'h2B8,12'h2B9,12'h2BA,12'h2BB,12'h2BC,12'h2BD,12'h2BE,12'h2BF,
    12'h2C8,12'h2C9,12'h2CA,12'h2CB,12'h2CC,12'h2CD,12'h2CE,12'h2CF,
    12'h2D8,12'h2D9,12'h2DA,12'h2DB,12'h2DC,12'h2DD,12'h2DE,12'h2DF,
    12'h2E8,12'h2E9,12'h2EA,12'h2EB,12'h2EC,12'h2ED,12'h2EE,12'h2EF,
    12'h0B9,12'h0BA,12'h0BB,12'h0BC,12'h0BD,12'h0BE,12'h0BF,12'h0C8,
    12'h0C9,12'h0CA,12'h0CB,12'h0CC,12'h0CD,12'h0CE,12'h0CF,12'h0D8,
    12'h0D9,12'h0DA,12'h0DB,12'h0DC,12'h0DD,12'h0DE,12'h0DF,12'h0E8,
    12'h0E9,12'h0EA,12'h0EB,12'h0EC,12'h0ED,12'h0EE,12'h0EF,12'h0F8,
    12'h0F9,12'h0FA,12'h0FB,12'h0FC,12'h0FD,12'h0FE,12'h0FF,12'h188,
    12'h189,12'h18A,12'h18B,12'h18C,12'h18D,12'h18E,12'h18F,12'h198,
    12'h199,12'h19A,12'h19B,12'h19C,12'h19D,12'h19E,12'h19F,12'h1A8,
    12'h1A9,12'h1AA,12'h1AB,12'h1AC,12'h1AD,12'h1AE,12'h1AF,12'h1B8,
    12'h1B9,12'h1BA,12'h1BB,12'h1BC,12'h1BD,12'h1BE,12'h1BF,12'h1C8,
    12'h1C9,12'h1CA,12'h1CB,12'h1CC,12'h1CD,12'h1CE,12'h1CF,12'h1D8,
    12'h1D9,12'h1DA,12'h1DB,12'h1DC,12'h1DD,12'h1DE,12'h1DF,12'h1E8,
    12'h1E9,12'h1EA,12'h1EB,12'h1EC,12'h1ED,12'h1EE,12'h1EF,12'h1F8
  };

  typedef struct {
    logic [7:0]  ch;
    logic [4:0]  tone;
    logic [11:0] dac;
    logic        last;
  } tone_item_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_we;
  logic [dxifk_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [dxifk_pkg::DAC_W-1:0]          cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [7:0]                           char_code;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [dxifk_pkg::TONE_W-1:0]         tone_index;
  logic [dxifk_pkg::DAC_W-1:0]          dac_code;
  logic                                 last_symbol;

  // Model state: register copies and the tone carried between characters
  logic [7:0]   spacing_now;
  logic [11:0]  base_now;
  int unsigned  prev_tone;
  tone_item_t   pending_tones[$];

  int           errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  holds_asked = 0;
  int unsigned  holds_taken = 0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;

  dominoex_ifk_tone_encoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tone_index  (tone_index),
    .dac_code    (dac_code),
    .last_symbol (last_symbol)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push the tones that one character produces and advance the tone state
  function automatic void encode_char(input logic [7:0] ch);
    logic [11:0]  entry;
    logic [3:0]   nib [3];
    int unsigned  count;
    int unsigned  sum;
    tone_item_t   t;
    entry  = VARICODE[ch];
    nib[0] = entry[11:8];
    nib[1] = entry[7:4];
    nib[2] = entry[3:0];
    count  = 1;
    if (nib[1][3]) begin
      count = nib[2][3] ? 3 : 2;
    end
    for (int i = 0; i < count; i++) begin
      prev_tone = (prev_tone + STEP + nib[i]) % TONES;
      sum       = base_now + prev_tone * spacing_now;
      t.ch      = ch;
      t.tone    = prev_tone[4:0];
      t.dac     = (sum > DAC_TOP) ? 12'(DAC_TOP) : sum[11:0];
      t.last    = (i == count - 1);
      pending_tones.push_back(t);
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] ch,
                                      input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      $display("%0t: char %0d %s mismatch: expected %0d, got %0d", $time, ch, what,
               want, got);
      errors++;
    end
  endfunction

  // Offer one character after a random gap; record its tones on acceptance
  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= ch;
    do @(posedge clk); while (in_ready !== 1'b1);
    encode_char(ch);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Wait for every expected tone, then let the block settle
  task automatic wait_drained();
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dxifk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [11:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dxifk_pkg::REG_TONE_SPACING: spacing_now = data[7:0];
      dxifk_pkg::REG_BASE_LEVEL:   base_now    = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_levels(input logic [7:0] spacing, input logic [11:0] base);
    // upper data bits are random: the spacing register must drop them
    write_reg(dxifk_pkg::REG_TONE_SPACING, {4'($urandom), spacing});
    write_reg(dxifk_pkg::REG_BASE_LEVEL, base);
  endtask

  // Reset values, one- to three-tone characters, all-zero and all-one codes
  task automatic test_reset_levels();
    logic [7:0] chars [9] = '{8'd0, 8'd255, 8'd32, 8'd97, 8'd101, 8'd8, 8'd127,
                              8'd85, 8'd170};
    send_idle_pct = 37;
    recv_idle_pct = 57;
    foreach (chars[i]) send_char(chars[i]);
    stop_sending();
    wait_drained();
  endtask

  // Register extremes, saturation of the DAC code included
  task automatic test_level_extremes();
    logic [7:0]  spacings [5] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd17};
    logic [11:0] bases [5]    = '{12'd0, 12'd4095, 12'd2000, 12'd4095, 12'd1};
    foreach (spacings[i]) begin
      set_levels(spacings[i], bases[i]);
      send_char(8'd7);
      send_char(8'd255);
      send_char(8'd32);
      stop_sending();
      wait_drained();
    end
  endtask

  // Random characters over the three idling phases and several settings
  task automatic test_random_chars();
    int unsigned send_pct [3] = '{37, 57, 0};
    int unsigned recv_pct [3] = '{57, 37, 0};
    logic [7:0]  spacing;
    logic [11:0] base;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(3))
          0: spacing = 8'd0;
          1: spacing = 8'd255;
          default: spacing = 8'($urandom);
        endcase
        case ($urandom_range(3))
          0: base = 12'd0;
          1: base = 12'd4095;
          default: base = 12'($urandom);
        endcase
        if (p == 2 && s == 3) begin
          spacing = dxifk_pkg::SPACING_RESET;
          base    = dxifk_pkg::BASE_RESET;
        end
        set_levels(spacing, base);
        repeat (38) send_char(8'($urandom_range(255)));
        stop_sending();
        wait_drained();
      end
    end
  endtask

  // Long receiver hold-off with the sender pushing, then a drained pause and a round with random receiver stalls
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    repeat (20) send_char(8'($urandom_range(255)));
    stop_sending();
    wait_drained();
    recv_idle_pct = 30;
    repeat (20) send_char(8'($urandom_range(255)));
    stop_sending();
    wait_drained();
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      holds_taken <= holds_taken + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted tone with the oldest expected one
  always @(posedge clk) begin
    tone_item_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_tones.size() == 0) begin
        $display("%0t: unexpected tone: expected none, got tone %0d dac %0d last %0d",
                 $time, tone_index, dac_code, last_symbol);
        errors++;
      end else begin
        want = pending_tones.pop_front();
        check_field("tone_index", want.ch, 12'(want.tone), 12'(tone_index));
        check_field("dac_code", want.ch, want.dac, dac_code);
        check_field("last_symbol", want.ch, 12'(want.last), 12'(last_symbol));
      end
    end
  end

  // Abort when no item moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
      $display("tb_dominoex_ifk_tone_encoder_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    char_code   = '0;
    out_ready   = 1'b0;
    spacing_now = 8'd25;
    base_now    = 12'd2103;
    prev_tone   = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_levels();
    test_level_extremes();
    test_random_chars();
    test_output_stall();

    if (errors == 0) begin
      $display("tb_dominoex_ifk_tone_encoder_unit passed");
    end else begin
      $display("tb_dominoex_ifk_tone_encoder_unit failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/dxifk_pkg.sv
rtl/core/dxifk_ctrl.sv
rtl/core/dxifk_datapath.sv
rtl/core/dominoex_ifk_tone_encoder_unit.sv
tb/tb_dominoex_ifk_tone_encoder_unit.sv
